### hdl/compact_serializer_token_encoder_assert.svh
// Assertion helpers shared by the checker.
`ifndef COMPACT_SERIALIZER_TOKEN_ENCODER_ASSERT_SVH
`define COMPACT_SERIALIZER_TOKEN_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cste assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cste assertion failed");

`endif

### hdl/cste_pkg.sv
package cste_pkg;

  localparam int unsigned NEST_DEPTH_DEF = 16;

  typedef struct packed {
    logic        [3:0]  mode;
    logic        [3:0]  type_a;
    logic        [3:0]  type_b;
    logic signed [15:0] field_id;
    logic signed [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // token modes
  localparam logic [3:0] MODE_STRUCT_BEGIN = 4'd0;
  localparam logic [3:0] MODE_STRUCT_END   = 4'd1;
  localparam logic [3:0] MODE_FIELD_BEGIN  = 4'd2;
  localparam logic [3:0] MODE_STOP         = 4'd3;
  localparam logic [3:0] MODE_LIST         = 4'd4;
  localparam logic [3:0] MODE_MAP          = 4'd5;
  localparam logic [3:0] MODE_I16          = 4'd6;
  localparam logic [3:0] MODE_I32          = 4'd7;
  localparam logic [3:0] MODE_I64          = 4'd8;
  localparam logic [3:0] MODE_BYTE         = 4'd9;
  localparam logic [3:0] MODE_BOOL         = 4'd10;

  localparam logic [3:0] TYPE_IDX_BOOL   = 4'd1;
  localparam logic [3:0] BOOL_CODE_TRUE  = 4'h1;
  localparam logic [3:0] BOOL_CODE_FALSE = 4'h2;
  localparam logic [3:0] LONG_LIST_NIB   = 4'hF;
  localparam logic [31:0] LIST_SHORT_MAX = 32'd14;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic pop_done;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop;
    logic busy;
    logic last;
  } sts_t;

  // type index to compact wire type code
  function automatic logic [3:0] map_type(input logic [3:0] idx);
    logic [3:0] code;
    case (idx)
      4'd0:    code = 4'd0;
      4'd1:    code = 4'd1;
      4'd2:    code = 4'd3;
      4'd3:    code = 4'd4;
      4'd4:    code = 4'd5;
      4'd5:    code = 4'd6;
      4'd6:    code = 4'd7;
      4'd7:    code = 4'd8;
      4'd8:    code = 4'd9;
      4'd9:    code = 4'd10;
      4'd10:   code = 4'd11;
      4'd11:   code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

### hdl/cste_ram.sv
module cste_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cste_ctrl.sv
module cste_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cste_pkg::sts_t sts_i,
  output cste_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_POP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.pop ? S_POP : S_EMIT;
      end
      S_POP: begin
        // stack read data is valid this cycle
        cmd_o.pop_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_EMIT: begin
        if (!sts_i.busy) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/cste_dp.sv
module cste_dp #(
  parameter int unsigned NEST_DEPTH = cste_pkg::NEST_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cste_pkg::in_t  in_data_i,
  input  cste_pkg::cmd_t cmd_i,
  output cste_pkg::sts_t sts_o,
  output cste_pkg::out_t out_data_o
);

  localparam int unsigned LvlW  = $clog2(NEST_DEPTH + 1);
  localparam int unsigned AddrW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  cste_pkg::in_t  tok_q;
  cste_pkg::out_t out_q;

  logic [15:0]     last_id_q, last_id_d;
  logic [LvlW-1:0] level_q, level_d, level_dec;
  logic            pending_q, pending_d;
  logic [15:0]     bool_id_q, bool_id_d;

  // emit plan: optional prefix byte, optional varint, optional suffix byte
  logic        has_pre_q, has_pre_d;
  logic [7:0]  pre_q, pre_d;
  logic        has_var_q, has_var_d;
  logic [63:0] var_q, var_d;
  logic        has_suf_q, has_suf_d;
  logic [7:0]  suf_q, suf_d;

  logic        push_ok, nonempty;
  logic [15:0] stk_rdata;
  logic [15:0] hdr_id;
  logic [3:0]  hdr_code, code_a, code_b, bool_code;
  logic [16:0] delta;
  logic        delta_short;
  logic [31:0] v32, hdr_id32, i16_32;
  logic [63:0] val;
  logic        var_more;
  logic [7:0]  emit_byte;
  logic        emit_last;

  assign val       = tok_q.value;
  assign v32       = val[31:0];
  assign code_a    = cste_pkg::map_type(tok_q.type_a);
  assign code_b    = cste_pkg::map_type(tok_q.type_b);
  assign bool_code = (val != 64'd0) ? cste_pkg::BOOL_CODE_TRUE : cste_pkg::BOOL_CODE_FALSE;

  assign push_ok   = (level_q < LvlW'(NEST_DEPTH));
  assign nonempty  = (level_q != '0);
  assign level_dec = level_q - LvlW'(1);

  // field header shared by field begin and a pending bool
  assign hdr_id      = (tok_q.mode == cste_pkg::MODE_BOOL) ? bool_id_q : tok_q.field_id;
  assign hdr_code    = (tok_q.mode == cste_pkg::MODE_BOOL) ? bool_code : code_a;
  assign delta       = {hdr_id[15], hdr_id} - {last_id_q[15], last_id_q};
  assign delta_short = !delta[16] && (delta[15:4] == '0) && (delta[3:0] != '0);
  assign hdr_id32    = {{16{hdr_id[15]}}, hdr_id};
  assign i16_32      = {{16{val[15]}}, val[15:0]};

  cste_ram #(
    .Width (16),
    .Depth (NEST_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.setup && (tok_q.mode == cste_pkg::MODE_STRUCT_BEGIN) && push_ok),
    .waddr_i (level_q[AddrW-1:0]),
    .wdata_i (last_id_q),
    .re_i    (cmd_i.setup && sts_o.pop),
    .raddr_i (level_dec[AddrW-1:0]),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    last_id_d = last_id_q;
    level_d   = level_q;
    pending_d = pending_q;
    bool_id_d = bool_id_q;
    has_pre_d = has_pre_q;
    pre_d     = pre_q;
    has_var_d = has_var_q;
    var_d     = var_q;
    has_suf_d = has_suf_q;
    suf_d     = suf_q;

    if (cmd_i.setup) begin
      has_pre_d = 1'b0;
      has_var_d = 1'b0;
      has_suf_d = 1'b0;
      case (tok_q.mode)
        cste_pkg::MODE_STRUCT_BEGIN: begin
          if (push_ok) begin
            level_d = level_q + LvlW'(1);
          end
          last_id_d = '0;
        end
        cste_pkg::MODE_STRUCT_END: begin
          if (nonempty) begin
            level_d = level_dec;
          end else begin
            last_id_d = '0;
          end
        end
        cste_pkg::MODE_FIELD_BEGIN, cste_pkg::MODE_BOOL: begin
          if (tok_q.mode == cste_pkg::MODE_FIELD_BEGIN && tok_q.type_a == cste_pkg::TYPE_IDX_BOOL)
          begin
            pending_d = 1'b1;
            bool_id_d = tok_q.field_id;
          end else if (tok_q.mode == cste_pkg::MODE_BOOL && !pending_q) begin
            has_pre_d = 1'b1;
            pre_d     = {4'h0, bool_code};
          end else begin
            pending_d = 1'b0;
            has_pre_d = 1'b1;
            last_id_d = hdr_id;
            if (delta_short) begin
              pre_d = {delta[3:0], hdr_code};
            end else begin
              pre_d     = {4'h0, hdr_code};
              has_var_d = 1'b1;
              var_d     = {32'd0, hdr_id32[30:0], 1'b0} ^ {32'd0, {32{hdr_id32[31]}}};
            end
          end
        end
        cste_pkg::MODE_STOP: begin
          has_pre_d = 1'b1;
          pre_d     = 8'h00;
        end
        cste_pkg::MODE_LIST: begin
          has_pre_d = 1'b1;
          if (v32 <= cste_pkg::LIST_SHORT_MAX) begin
            pre_d = {v32[3:0], code_a};
          end else begin
            pre_d     = {cste_pkg::LONG_LIST_NIB, code_a};
            has_var_d = 1'b1;
            var_d     = {32'd0, v32};
          end
        end
        cste_pkg::MODE_MAP: begin
          if (v32 == 32'd0) begin
            has_pre_d = 1'b1;
            pre_d     = 8'h00;
          end else begin
            has_var_d = 1'b1;
            var_d     = {32'd0, v32};
            has_suf_d = 1'b1;
            suf_d     = {code_a, code_b};
          end
        end
        cste_pkg::MODE_I16: begin
          has_var_d = 1'b1;
          var_d     = {32'd0, i16_32[30:0], 1'b0} ^ {32'd0, {32{i16_32[31]}}};
        end
        cste_pkg::MODE_I32: begin
          has_var_d = 1'b1;
          var_d     = {32'd0, v32[30:0], 1'b0} ^ {32'd0, {32{v32[31]}}};
        end
        cste_pkg::MODE_I64: begin
          has_var_d = 1'b1;
          var_d     = {val[62:0], 1'b0} ^ {64{val[63]}};
        end
        cste_pkg::MODE_BYTE: begin
          has_pre_d = 1'b1;
          pre_d     = val[7:0];
        end
        default: ;
      endcase
    end

    if (cmd_i.pop_done) begin
      last_id_d = stk_rdata;
    end

    if (cmd_i.emit) begin
      if (has_pre_q) begin
        has_pre_d = 1'b0;
      end else if (has_var_q) begin
        var_d     = {7'd0, var_q[63:7]};
        has_var_d = var_more;
      end else begin
        has_suf_d = 1'b0;
      end
    end
  end

  // next byte of the plan and whether nothing follows it
  assign var_more = (var_q[63:7] != '0);

  always_comb begin
    if (has_pre_q) begin
      emit_byte = pre_q;
      emit_last = !has_var_q && !has_suf_q;
    end else if (has_var_q) begin
      emit_byte = {var_more, var_q[6:0]};
      emit_last = !var_more && !has_suf_q;
    end else begin
      emit_byte = suf_q;
      emit_last = 1'b1;
    end
  end

  assign sts_o.pop  = (tok_q.mode == cste_pkg::MODE_STRUCT_END) && nonempty;
  assign sts_o.busy = has_pre_q || has_var_q || has_suf_q;
  assign sts_o.last = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q <= '0;
      level_q   <= '0;
      pending_q <= 1'b0;
      bool_id_q <= '0;
      has_pre_q <= 1'b0;
      has_var_q <= 1'b0;
      has_suf_q <= 1'b0;
    end else begin
      last_id_q <= last_id_d;
      level_q   <= level_d;
      pending_q <= pending_d;
      bool_id_q <= bool_id_d;
      has_pre_q <= has_pre_d;
      has_var_q <= has_var_d;
      has_suf_q <= has_suf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tok_q <= in_data_i;
    end
    pre_q <= pre_d;
    var_q <= var_d;
    suf_q <= suf_d;
    if (cmd_i.emit) begin
      out_q.out_byte  <= emit_byte;
      out_q.last_byte <= emit_last;
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/compact_serializer_token_encoder.sv
// Compact wire-format token encoder.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one serializer token
// per transaction; output channel (out_valid_o/out_ready_i, out_data_o) gives
// the wire bytes one per transaction, last_byte set on the final byte of a
// token. Tokens that produce no bytes (struct begin/end, bool field begin,
// unknown modes) update at most the field-id and nesting state.
// Timing: a token is taken in the idle state and decoded in the setup state,
// then one byte leaves the output register per cycle while the receiver is
// ready. Tokens with no bytes emit nothing; struct end on a nonempty stack
// also waits in the pop state on the id-stack RAM read. An i64 varint takes
// up to 10 bytes. The byte loop, one varint group per cycle, sets the rate.
// The nesting stack is a NEST_DEPTH x 16 RAM; it needs no clearing, as only
// entries below the current level are ever read.
// Reset clears the last field id, stack level, pending bool and output valid.
// When the receiver stalls, the current byte holds in the output register and
// the encoder waits; the next token is taken once the last byte is loaded.
module compact_serializer_token_encoder #(
  parameter int unsigned NEST_DEPTH = cste_pkg::NEST_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cste_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cste_pkg::out_t out_data_o
);

  cste_pkg::cmd_t cmd;
  cste_pkg::sts_t sts;

  cste_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cste_dp #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

### hdl/cste_checker.sv
`include "compact_serializer_token_encoder_assert.svh"

module cste_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input cste_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cste_pkg::out_t out_data_o
);

  // a stalled output byte holds
  `CSTE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // while a non-final byte sits in the output, the token is still in flight
  `CSTE_ASSERT_NOW(a_busy_mid_token, clk_i, rst_ni, out_valid_o && !out_data_o.last_byte, !in_ready_o)

  // a plain byte token keeps the input closed for decode and emit
  `CSTE_ASSERT_NEXT(a_byte_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.mode == cste_pkg::MODE_BYTE), !in_ready_o ##1 !in_ready_o)

endmodule

bind compact_serializer_token_encoder cste_checker u_cste_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
